@@ src/stree_pkg.sv @@
// Shared constants and controller/datapath interface types for the segment tree range sum block.
// No dependencies.
`default_nettype none

package stree_pkg;

   localparam int unsigned LEAVES_DEFAULT = 1024;
   localparam int unsigned ELEM_W = 11;
   localparam int unsigned POS_W = 10;
   localparam int unsigned DATA_W = 32;
   localparam logic [ELEM_W-1:0] ELEM_COUNT_RESET = 11'd1024;

   localparam logic OP_UPDATE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic load;
      logic clear_write;
      logic node_write;
      logic climb;
      logic read_lo;
      logic step_hi;
      logic respond;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic op;
      logic bad;
      logic empty;
      logic root;
      logic lo_lt_hi;
   } status_type;

endpackage

`default_nettype wire

@@ src/stree_dpath.sv @@
// Datapath of the segment tree: node sum memory, walk registers, accumulator, result word.
// Depends on stree_pkg.
`default_nettype none

module stree_dpath #(
   parameter int unsigned LEAVES = stree_pkg::LEAVES_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire stree_pkg::cmd_type                   cmd,
   output stree_pkg::status_type                     status,
   input  wire logic                                 csr_write_enable,
   input  wire logic [stree_pkg::ELEM_W-1:0]         csr_write_data,
   input  wire logic                                 req_operation,
   input  wire logic [stree_pkg::POS_W-1:0]          req_position,
   input  wire logic signed [stree_pkg::DATA_W-1:0]  req_new_value,
   input  wire logic [stree_pkg::POS_W-1:0]          req_range_first,
   input  wire logic [stree_pkg::POS_W-1:0]          req_range_last,
   output logic signed [stree_pkg::DATA_W-1:0]       rsp_sum_out,
   output logic                                      rsp_was_query,
   output logic                                      rsp_rejected
);

   localparam int unsigned NODES = 2 * LEAVES;
   localparam int unsigned IDX_W = $clog2(NODES);
   localparam int unsigned HW = IDX_W + 1;
   localparam int unsigned CNT_W = ($clog2(LEAVES + 1) > stree_pkg::ELEM_W) ?
                                   $clog2(LEAVES + 1) : stree_pkg::ELEM_W;
   localparam int unsigned DW = stree_pkg::DATA_W;

   logic [DW-1:0]                   mem [NODES];
   logic [DW-1:0]                   rd_data_ff;
   logic [stree_pkg::ELEM_W-1:0]    elem_count_ff;
   logic [IDX_W-1:0]                clr_addr_ff;
   logic                            add_pending_ff, add_pending_in;
   logic                            op_ff, bad_ff, empty_ff;
   logic [IDX_W-1:0]                idx_ff;
   logic [HW-1:0]                   lo_ff, hi_ff;
   logic [DW-1:0]                   cur_ff, acc_ff;
   logic [DW-1:0]                   rsp_sum_ff;
   logic                            rsp_was_query_ff, rsp_rejected_ff;

   logic [CNT_W-1:0]                cnt_eff, lim, last_clip;
   logic [CNT_W-1:0]                elem_ext, pos_ext, first_ext, last_ext;
   logic                            bad_in, empty_in;
   logic [HW-1:0]                   hi_minus;
   logic [IDX_W-1:0]                wr_addr, rd_addr;
   logic                            wr_en;
   logic [DW-1:0]                   wr_data;

   always_comb begin
      elem_ext = CNT_W'(elem_count_ff);
      cnt_eff = (elem_ext > CNT_W'(LEAVES)) ? CNT_W'(LEAVES) : elem_ext;
      pos_ext = CNT_W'(req_position);
      first_ext = CNT_W'(req_range_first);
      last_ext = CNT_W'(req_range_last);
      lim = cnt_eff - CNT_W'(1);
      last_clip = (last_ext > lim) ? lim : last_ext;
      bad_in = pos_ext >= cnt_eff;
      empty_in = (cnt_eff == '0) || (first_ext > last_clip);
   end

   assign hi_minus = hi_ff - HW'(1);

   always_comb begin
      wr_en = cmd.clear_write | cmd.node_write;
      wr_addr = cmd.clear_write ? clr_addr_ff : idx_ff;
      wr_data = cmd.clear_write ? '0 : cur_ff;
      case (1'b1)
         cmd.read_lo: rd_addr = lo_ff[IDX_W-1:0];
         cmd.step_hi: rd_addr = hi_minus[IDX_W-1:0];
         default:     rd_addr = idx_ff ^ IDX_W'(1);
      endcase
   end

   assign add_pending_in = (cmd.read_lo & lo_ff[0]) | (cmd.step_hi & hi_ff[0]);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elem_count_ff <= stree_pkg::ELEM_COUNT_RESET;
         clr_addr_ff <= '0;
         add_pending_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            elem_count_ff <= csr_write_data;
         end
         if (cmd.clear_write) begin
            clr_addr_ff <= clr_addr_ff + IDX_W'(1);
         end
         add_pending_ff <= add_pending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_operation;
         bad_ff <= bad_in;
         empty_ff <= empty_in;
         idx_ff <= IDX_W'(pos_ext) + IDX_W'(LEAVES);
         cur_ff <= $unsigned(req_new_value);
         lo_ff <= HW'(first_ext) + HW'(LEAVES);
         hi_ff <= HW'(last_clip) + HW'(LEAVES) + HW'(1);
         acc_ff <= '0;
      end else begin
         if (cmd.climb) begin
            cur_ff <= cur_ff + rd_data_ff;
            idx_ff <= idx_ff >> 1;
         end
         if (cmd.step_hi) begin
            lo_ff <= (lo_ff + HW'(lo_ff[0])) >> 1;
            hi_ff <= hi_ff >> 1;
         end
         if (add_pending_ff) begin
            acc_ff <= acc_ff + rd_data_ff;
         end
      end
      if (cmd.respond) begin
         rsp_sum_ff <= acc_ff;
         rsp_was_query_ff <= op_ff;
         rsp_rejected_ff <= (op_ff == stree_pkg::OP_UPDATE) & bad_ff;
      end
   end

   always_comb begin
      status.clear_done = clr_addr_ff == IDX_W'(NODES - 1);
      status.op = op_ff;
      status.bad = bad_ff;
      status.empty = empty_ff;
      status.root = idx_ff == IDX_W'(1);
      status.lo_lt_hi = lo_ff < hi_ff;
   end

   assign rsp_sum_out = $signed(rsp_sum_ff);
   assign rsp_was_query = rsp_was_query_ff;
   assign rsp_rejected = rsp_rejected_ff;

   a_add_only_in_query: assert property (@(posedge clock) disable iff (reset)
      add_pending_ff |-> (op_ff == stree_pkg::OP_QUERY))
      else $error("accumulator add outside a query");

endmodule

`default_nettype wire

@@ src/stree_ctrl.sv @@
// Controller of the segment tree: clearing pass, update climb and query walk sequencing.
// Depends on stree_pkg.
`default_nettype none

module stree_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output stree_pkg::cmd_type          cmd,
   input  wire stree_pkg::status_type  status
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_WRITE,
      ST_CLIMB,
      ST_QLO,
      ST_QHI,
      ST_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_write = 1'b1;
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (status.op == stree_pkg::OP_UPDATE) begin
               state_in = status.bad ? ST_RESP : ST_WRITE;
            end else begin
               state_in = status.empty ? ST_RESP : ST_QLO;
            end
         end
         ST_WRITE: begin
            cmd.node_write = 1'b1;
            state_in = status.root ? ST_RESP : ST_CLIMB;
         end
         ST_CLIMB: begin
            cmd.climb = 1'b1;
            state_in = ST_WRITE;
         end
         ST_QLO: begin
            if (status.lo_lt_hi) begin
               cmd.read_lo = 1'b1;
               state_in = ST_QHI;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_QHI: begin
            cmd.step_hi = 1'b1;
            state_in = ST_QLO;
         end
         ST_RESP: begin
            if (out_free) begin
               cmd.respond = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESP))
      else $error("result word raised outside the respond state");

   a_clear_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR && status.clear_done) |=> state_ff == ST_IDLE)
      else $error("clearing pass did not end at the last node");

   a_reject_skips_tree: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DISPATCH && status.op == stree_pkg::OP_UPDATE && status.bad)
      |=> state_ff == ST_RESP)
      else $error("rejected update touched the tree");

endmodule

`default_nettype wire

@@ src/segment_tree_range_sum.sv @@
// Top level of the segment tree range sum block: controller plus datapath.
// Depends on stree_pkg, stree_ctrl and stree_dpath.
`default_nettype none

// Segment tree of 2*LEAVES signed 32-bit node sums with point update and inclusive range sum,
// wrapping modulo 2^32; one result word per request word. After reset a clearing pass zeroes
// the node memory one entry a cycle, with req_stall high; elem_count writes are taken
// throughout. Work goes through the single-write, single-read node memory: an update does
// one write and one sibling read per level; a query does two memory reads per level. A
// rejected update or empty range goes straight to the respond state without touching the
// tree. One request is in progress at a time; the result register lets the next request be
// accepted while a result still waits.
module segment_tree_range_sum #(
   parameter int unsigned LEAVES = stree_pkg::LEAVES_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_write_enable,
   input  wire logic [stree_pkg::ELEM_W-1:0]         csr_write_data,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic                                 req_operation,
   input  wire logic [stree_pkg::POS_W-1:0]          req_position,
   input  wire logic signed [stree_pkg::DATA_W-1:0]  req_new_value,
   input  wire logic [stree_pkg::POS_W-1:0]          req_range_first,
   input  wire logic [stree_pkg::POS_W-1:0]          req_range_last,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic signed [stree_pkg::DATA_W-1:0]       rsp_sum_out,
   output logic                                      rsp_was_query,
   output logic                                      rsp_rejected
);

   stree_pkg::cmd_type    cmd;
   stree_pkg::status_type status;

   stree_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   stree_dpath #(
      .LEAVES (LEAVES)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_operation    (req_operation),
      .req_position     (req_position),
      .req_new_value    (req_new_value),
      .req_range_first  (req_range_first),
      .req_range_last   (req_range_last),
      .rsp_sum_out      (rsp_sum_out),
      .rsp_was_query    (rsp_was_query),
      .rsp_rejected     (rsp_rejected)
   );

endmodule

`default_nettype wire
